### rtl/latency_subsequence_table_builder_core_defines.svh
// ----------------------------------------------------------------------------
// latency subsequence table builder assertion macros
// shared property forms used by the core's checks
// ----------------------------------------------------------------------------
`ifndef LATENCY_SUBSEQUENCE_TABLE_BUILDER_CORE_DEFINES_SVH
`define LATENCY_SUBSEQUENCE_TABLE_BUILDER_CORE_DEFINES_SVH

// same-cycle implication
`define LSTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lstb check failed");

// next-cycle implication
`define LSTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lstb check failed");

`endif

### rtl/lstb_pkg.sv
// ----------------------------------------------------------------------------
// lstb package
// request and result types, sequencer states and fixed widths
// ----------------------------------------------------------------------------
package lstb_pkg;

  localparam int VERT_W  = 5;
  localparam int DADDR_W = 2 * VERT_W;
  localparam int DUR_W   = 22;
  localparam int COST_W  = 27;
  localparam int WGT_W   = 6;
  localparam int SUM_W   = 25;
  localparam int CSUM_W  = 28;
  localparam logic [DUR_W-1:0]  DUR_MAX  = '1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  localparam logic KIND_DIST   = 1'b0;
  localparam logic KIND_APPEND = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [VERT_W-1:0] from_vertex;
    logic [VERT_W-1:0] to_vertex;
    logic [15:0]       distance;
    logic [VERT_W-1:0] tour_vertex;
    logic              restart;
  } req_t;

  typedef struct packed {
    logic [VERT_W-1:0] start_pos;
    logic [VERT_W-1:0] end_pos;
    logic [DUR_W-1:0]  duration;
    logic [COST_W-1:0] cost;
    logic [WGT_W-1:0]  weight;
    logic [VERT_W-1:0] first_vertex;
    logic [VERT_W-1:0] final_vertex;
    logic              overflow;
    logic              last;
  } res_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SING,
    ST_DFETCH,
    ST_FWD,
    ST_RFETCH,
    ST_REV
  } state_t;

endpackage

### rtl/lstb_dist_mem.sv
// ----------------------------------------------------------------------------
// lstb distance memory
// vertex-pair distance store, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module lstb_dist_mem #(
  parameter int DIST_BITS = 16
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [lstb_pkg::DADDR_W-1:0] wr_addr,
  input  logic [DIST_BITS-1:0]        wr_data,
  input  logic [lstb_pkg::DADDR_W-1:0] rd_addr,
  output logic [DIST_BITS-1:0]        rd_data_r
);

  logic [DIST_BITS-1:0] mem [2**lstb_pkg::DADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule

### rtl/lstb_accum.sv
// ----------------------------------------------------------------------------
// lstb concatenation unit
// shared saturating adder joining an entry with one more edge and vertex
// ----------------------------------------------------------------------------
module lstb_accum #(
  parameter int DIST_BITS = 16
) (
  input  logic [lstb_pkg::DUR_W-1:0]  base_dur,
  input  logic [lstb_pkg::COST_W-1:0] base_cost,
  input  logic [lstb_pkg::WGT_W-1:0]  base_wgt,
  input  logic [DIST_BITS-1:0]        edge_dist,
  input  logic                        weighted,
  output logic [lstb_pkg::DUR_W-1:0]  dur,
  output logic [lstb_pkg::COST_W-1:0] cost,
  output logic [lstb_pkg::WGT_W-1:0]  wgt
);

  logic [lstb_pkg::SUM_W-1:0]  step;
  logic [lstb_pkg::CSUM_W-1:0] csum;

  always_comb begin
    step = lstb_pkg::SUM_W'(base_dur) + lstb_pkg::SUM_W'(edge_dist);
    csum = lstb_pkg::CSUM_W'(base_cost)
         + (weighted ? lstb_pkg::CSUM_W'(step) : '0);
    dur  = (step > lstb_pkg::SUM_W'(lstb_pkg::DUR_MAX))
         ? lstb_pkg::DUR_MAX : step[lstb_pkg::DUR_W-1:0];
    cost = (csum > lstb_pkg::CSUM_W'(lstb_pkg::COST_MAX))
         ? lstb_pkg::COST_MAX : csum[lstb_pkg::COST_W-1:0];
    wgt  = base_wgt + lstb_pkg::WGT_W'(weighted);
  end

endmodule

### rtl/latency_subsequence_table_builder_core.sv
// ----------------------------------------------------------------------------
// latency subsequence table builder core
// Distance requests (kind 0) write the vertex-pair distance memory and give
// no result. An append request (kind 1) places a vertex at the next tour
// position j and a small sequencer then drives one shared saturating
// concatenation unit: it emits the singleton (j..j), the forward entries
// (i..j) for i = 0..j-1, updating the per-start column store as it goes, and
// the reversed entries (j..i) for i = j-1 down to 0, the last one marked with
// last. An append to a full tour returns a single overflow result. An append
// steps through accepting the request, the singleton, a fetch of the joining
// edge, the forward entries, and a fetch step and an emit step per reversed
// entry, because each reversed step needs a fresh lookup from the single
// registered read port of the distance memory; at position 0 it ends after
// the singleton. The block takes no new request until the current one has
// issued its last result.
// ----------------------------------------------------------------------------
`include "latency_subsequence_table_builder_core_defines.svh"

module latency_subsequence_table_builder_core #(
  parameter int MAX_VERTICES = 32,
  parameter int DIST_BITS    = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  lstb_pkg::req_t   in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output lstb_pkg::res_t   out_data
);

  localparam int PW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(MAX_VERTICES);

  // sequencer state and per-request context
  lstb_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]              pos_cnt_r;
  logic [PW-1:0]              j_r, i_r, i_nxt;
  logic [lstb_pkg::VERT_W-1:0] vj_r, pv_r, nv_r;
  logic [DIST_BITS-1:0]       d_r;
  logic [lstb_pkg::DUR_W-1:0]  rt_r;
  logic [lstb_pkg::COST_W-1:0] rc_r;
  logic [lstb_pkg::WGT_W-1:0]  rw_r;

  // result register
  logic           out_valid_r;
  lstb_pkg::res_t out_r;

  // tour and column stores
  logic [lstb_pkg::VERT_W-1:0] tour_mem [MAX_VERTICES];
  logic [lstb_pkg::DUR_W-1:0]  col_dur  [MAX_VERTICES];
  logic [lstb_pkg::COST_W-1:0] col_cost [MAX_VERTICES];
  logic [lstb_pkg::WGT_W-1:0]  col_wgt  [MAX_VERTICES];

  logic                        in_acc, slot_free, emit;
  lstb_pkg::res_t              res;
  logic [CW-1:0]               cnt_eff;
  logic                        full;
  logic [PW-1:0]               tour_rd_addr, p_idx;
  logic [lstb_pkg::VERT_W-1:0] tour_rd;
  logic [lstb_pkg::DADDR_W-1:0] dist_rd_addr;
  logic [DIST_BITS-1:0]        dist_rd_data, dist_wr_data;
  logic [DIST_BITS+15:0]       dist_wide;

  // shared unit operands
  logic [lstb_pkg::DUR_W-1:0]  base_dur, acc_dur;
  logic [lstb_pkg::COST_W-1:0] base_cost, acc_cost;
  logic [lstb_pkg::WGT_W-1:0]  base_wgt, acc_wgt;
  logic [DIST_BITS-1:0]        acc_dist;
  logic                        acc_weighted;

  // a request only enters in idle with room for an overflow result
  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != lstb_pkg::ST_IDLE) || !slot_free;
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign cnt_eff = in_data.restart ? '0 : pos_cnt_r;
  assign full    = (cnt_eff == CNT_FULL);
  assign p_idx   = i_r - PW'(1);
  assign tour_rd = tour_mem[tour_rd_addr];

  // distance stored as its low DIST_BITS bits
  assign dist_wide    = (DIST_BITS + 16)'(in_data.distance);
  assign dist_wr_data = dist_wide[DIST_BITS-1:0];

  lstb_dist_mem #(.DIST_BITS(DIST_BITS)) u_dist (
    .clk       (clk),
    .wr_en     (in_acc && (in_data.kind == lstb_pkg::KIND_DIST)),
    .wr_addr   ({in_data.from_vertex, in_data.to_vertex}),
    .wr_data   (dist_wr_data),
    .rd_addr   (dist_rd_addr),
    .rd_data_r (dist_rd_data)
  );

  lstb_accum #(.DIST_BITS(DIST_BITS)) u_accum (
    .base_dur  (base_dur),
    .base_cost (base_cost),
    .base_wgt  (base_wgt),
    .edge_dist (acc_dist),
    .weighted  (acc_weighted),
    .dur       (acc_dur),
    .cost      (acc_cost),
    .wgt       (acc_wgt)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lstb_pkg::ST_IDLE: begin
        if (in_acc && (in_data.kind == lstb_pkg::KIND_APPEND) && !full) begin
          state_nxt = lstb_pkg::ST_SING;
        end
      end
      lstb_pkg::ST_SING: begin
        if (slot_free) begin
          state_nxt = (j_r == '0) ? lstb_pkg::ST_IDLE : lstb_pkg::ST_DFETCH;
        end
      end
      lstb_pkg::ST_DFETCH: state_nxt = lstb_pkg::ST_FWD;
      lstb_pkg::ST_FWD: begin
        if (slot_free && (i_r == j_r - PW'(1))) begin
          state_nxt = lstb_pkg::ST_RFETCH;
        end
      end
      lstb_pkg::ST_RFETCH: state_nxt = lstb_pkg::ST_REV;
      lstb_pkg::ST_REV: begin
        if (slot_free) begin
          state_nxt = (p_idx == '0) ? lstb_pkg::ST_IDLE : lstb_pkg::ST_RFETCH;
        end
      end
      default: state_nxt = lstb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: read addresses, shared unit operands, result
  always_comb begin
    tour_rd_addr = i_r;
    dist_rd_addr = {pv_r, nv_r};
    base_dur     = rt_r;
    base_cost    = rc_r;
    base_wgt     = rw_r;
    acc_dist     = dist_rd_data;
    acc_weighted = (p_idx != '0);
    emit         = 1'b0;
    i_nxt        = i_r;
    res          = '0;
    unique case (state_r)
      lstb_pkg::ST_IDLE: begin
        // full tour: lone overflow result
        if (in_acc && (in_data.kind == lstb_pkg::KIND_APPEND) && full) begin
          emit         = 1'b1;
          res.overflow = 1'b1;
          res.last     = 1'b1;
        end
      end
      lstb_pkg::ST_SING: begin
        // emit the singleton and fetch the joining edge for the forward pass
        tour_rd_addr     = j_r - PW'(1);
        dist_rd_addr     = {tour_rd, vj_r};
        emit             = slot_free;
        res.start_pos    = lstb_pkg::VERT_W'(j_r);
        res.end_pos      = lstb_pkg::VERT_W'(j_r);
        res.weight       = lstb_pkg::WGT_W'(j_r != '0);
        res.first_vertex = vj_r;
        res.final_vertex = vj_r;
        res.last         = (j_r == '0);
      end
      lstb_pkg::ST_DFETCH: begin
        tour_rd_addr = j_r - PW'(1);
        dist_rd_addr = {tour_rd, vj_r};
      end
      lstb_pkg::ST_FWD: begin
        // extend (i..j-1) by vertex j
        base_dur         = col_dur[i_r];
        base_cost        = col_cost[i_r];
        base_wgt         = col_wgt[i_r];
        acc_dist         = d_r;
        acc_weighted     = 1'b1;
        emit             = slot_free;
        res.start_pos    = lstb_pkg::VERT_W'(i_r);
        res.end_pos      = lstb_pkg::VERT_W'(j_r);
        res.duration     = acc_dur;
        res.cost         = acc_cost;
        res.weight       = acc_wgt;
        res.first_vertex = tour_rd;
        res.final_vertex = vj_r;
        i_nxt            = (i_r == j_r - PW'(1)) ? j_r : i_r + PW'(1);
      end
      lstb_pkg::ST_RFETCH: begin
        tour_rd_addr = p_idx;
        dist_rd_addr = {pv_r, tour_rd};
      end
      lstb_pkg::ST_REV: begin
        // extend (j..i) by vertex i-1, position 0 unweighted
        emit             = slot_free;
        res.start_pos    = lstb_pkg::VERT_W'(j_r);
        res.end_pos      = lstb_pkg::VERT_W'(p_idx);
        res.duration     = acc_dur;
        res.cost         = acc_cost;
        res.weight       = acc_wgt;
        res.first_vertex = vj_r;
        res.final_vertex = nv_r;
        res.last         = (p_idx == '0);
        i_nxt            = p_idx;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lstb_pkg::ST_IDLE;
      pos_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= emit || (out_valid_r && out_stall);
      if (in_acc && (in_data.kind == lstb_pkg::KIND_APPEND) && !full) begin
        pos_cnt_r <= cnt_eff + CW'(1);
      end
    end
  end

  // payload and store writes
  always_ff @(posedge clk) begin
    if (emit) begin
      out_r <= res;
    end
    unique case (state_r)
      lstb_pkg::ST_IDLE: begin
        if (in_acc && (in_data.kind == lstb_pkg::KIND_APPEND) && !full) begin
          j_r                          <= cnt_eff[PW-1:0];
          vj_r                         <= in_data.tour_vertex;
          tour_mem[cnt_eff[PW-1:0]]    <= in_data.tour_vertex;
          col_dur[cnt_eff[PW-1:0]]     <= '0;
          col_cost[cnt_eff[PW-1:0]]    <= '0;
          col_wgt[cnt_eff[PW-1:0]]     <= lstb_pkg::WGT_W'(cnt_eff != '0);
        end
      end
      lstb_pkg::ST_SING: begin
        i_r <= '0;
      end
      lstb_pkg::ST_DFETCH: begin
        d_r <= dist_rd_data;
      end
      lstb_pkg::ST_FWD: begin
        if (slot_free) begin
          col_dur[i_r]  <= acc_dur;
          col_cost[i_r] <= acc_cost;
          col_wgt[i_r]  <= acc_wgt;
          i_r           <= i_nxt;
          // seed the reversed walk from vertex j
          pv_r          <= vj_r;
          rt_r          <= '0;
          rc_r          <= '0;
          rw_r          <= lstb_pkg::WGT_W'(1);
        end
      end
      lstb_pkg::ST_RFETCH: begin
        nv_r <= tour_rd;
      end
      lstb_pkg::ST_REV: begin
        if (slot_free) begin
          rt_r <= acc_dur;
          rc_r <= acc_cost;
          rw_r <= acc_wgt;
          pv_r <= nv_r;
          i_r  <= i_nxt;
        end
      end
      default: begin
        i_r <= i_r;
      end
    endcase
  end

  // checks
  `LSTB_ASSERT_NOW(a_cnt_bound, 1'b1, pos_cnt_r <= CNT_FULL)
  `LSTB_ASSERT_NOW(a_ovf_last, out_valid_r && out_r.overflow, out_r.last)
  `LSTB_ASSERT_NOW(a_fwd_range, state_r == lstb_pkg::ST_FWD, i_r < j_r)
  `LSTB_ASSERT_NEXT(a_restart_cnt, in_acc && in_data.kind && in_data.restart, pos_cnt_r == CW'(1))

endmodule

### sim/tb_latency_subsequence_table_builder_core.sv
// ----------------------------------------------------------------------------
// latency subsequence table builder testbench
// Writes distances, appends tour vertices and checks every subsequence entry
// against a predictor of the table, with random idling on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_latency_subsequence_table_builder_core;

  localparam int NV        = 32;
  localparam int LAT_TAIL  = 200;
  localparam int N_RANDOM  = 320;
  localparam int RAND_V    = 7;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  lstb_pkg::req_t in_data;
  logic out_valid;
  logic out_stall;
  lstb_pkg::res_t out_data;

  latency_subsequence_table_builder_core #(
    .MAX_VERTICES(NV),
    .DIST_BITS(16)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // predictor state: mirrors the block's stores
  logic [15:0]                 dist_mem [NV*NV];
  bit                          dist_known [NV*NV];
  logic [lstb_pkg::VERT_W-1:0] tour_mem [NV];
  int unsigned                 tour_len;
  logic [lstb_pkg::DUR_W-1:0]  col_dur [NV];
  logic [lstb_pkg::COST_W-1:0] col_cost [NV];
  logic [lstb_pkg::WGT_W-1:0]  col_wgt [NV];

  lstb_pkg::res_t entry_q[$];
  int   n_errors;
  bit   idle_on;      // random idling enabled
  bit   hold_out;     // long receiver hold-off request
  int   hold_cycles;
  int   edge_mode;    // 0: longest edges, otherwise random lengths

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // generous fixed limit for the whole run
  initial begin
    #(4ns * 2000000);
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [lstb_pkg::DUR_W-1:0] sat_dur(logic [63:0] v);
    return (v > lstb_pkg::DUR_MAX) ? lstb_pkg::DUR_MAX : v[lstb_pkg::DUR_W-1:0];
  endfunction

  function automatic logic [lstb_pkg::COST_W-1:0] sat_cost(logic [63:0] v);
    return (v > lstb_pkg::COST_MAX) ? lstb_pkg::COST_MAX : v[lstb_pkg::COST_W-1:0];
  endfunction

  function automatic logic [63:0] edge_len(logic [lstb_pkg::VERT_W-1:0] a,
                                           logic [lstb_pkg::VERT_W-1:0] b);
    return 64'(dist_mem[{a, b}]);
  endfunction

  function automatic lstb_pkg::res_t mk_entry(int sp, int ep, logic [63:0] t,
                                              logic [63:0] c, int w,
                                              logic [lstb_pkg::VERT_W-1:0] fv,
                                              logic [lstb_pkg::VERT_W-1:0] lv);
    lstb_pkg::res_t r;
    r = '0;
    r.start_pos    = lstb_pkg::VERT_W'(sp);
    r.end_pos      = lstb_pkg::VERT_W'(ep);
    r.duration     = lstb_pkg::DUR_W'(t);
    r.cost         = lstb_pkg::COST_W'(c);
    r.weight       = lstb_pkg::WGT_W'(w);
    r.first_vertex = fv;
    r.final_vertex = lv;
    return r;
  endfunction

  // works out the table entries that one request gives, and queues them
  task automatic predict_entries(input lstb_pkg::req_t rq);
    int unsigned j;
    logic [lstb_pkg::VERT_W-1:0] vj;
    logic [63:0] d, stp, t, c;
    int w, wi;
    lstb_pkg::res_t r;
    if (rq.kind == lstb_pkg::KIND_DIST) begin
      dist_mem[{rq.from_vertex, rq.to_vertex}] = rq.distance;
      dist_known[{rq.from_vertex, rq.to_vertex}] = 1'b1;
      return;
    end
    if (rq.restart) tour_len = 0;
    if (tour_len >= NV) begin
      r = '0;
      r.overflow = 1'b1;
      r.last = 1'b1;
      entry_q.push_back(r);
      return;
    end
    j = tour_len;
    vj = rq.tour_vertex;
    tour_mem[j] = vj;
    tour_len++;
    entry_q.push_back(mk_entry(j, j, 0, 0, (j > 0) ? 1 : 0, vj, vj));
    if (j > 0) begin
      d = edge_len(tour_mem[j-1], vj);
      for (int i = 0; i < j; i++) begin
        stp = 64'(col_dur[i]) + d;
        col_dur[i] = sat_dur(stp);
        col_cost[i] = sat_cost(64'(col_cost[i]) + stp);
        col_wgt[i] = col_wgt[i] + 1'b1;
        entry_q.push_back(mk_entry(i, j, col_dur[i], col_cost[i], col_wgt[i],
                                   tour_mem[i], vj));
      end
    end
    col_dur[j] = '0;
    col_cost[j] = '0;
    col_wgt[j] = lstb_pkg::WGT_W'((j > 0) ? 1 : 0);
    t = 0;
    c = 0;
    w = (j > 0) ? 1 : 0;
    for (int i = j; i > 0; i--) begin
      wi = (i - 1 > 0) ? 1 : 0;
      stp = t + edge_len(tour_mem[i], tour_mem[i-1]);
      c = sat_cost(c + wi * stp);
      t = sat_dur(stp);
      w += wi;
      entry_q.push_back(mk_entry(j, i - 1, t, c, w, vj, tour_mem[i-1]));
    end
    entry_q[$].last = 1'b1;
  endtask

  // drives one request, holding it until accepted
  task automatic send_request(input lstb_pkg::req_t rq);
    int gap;
    if (idle_on && ($urandom_range(0, 3) == 0)) begin
      gap = $urandom_range(1, 11);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_entries(rq);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function automatic lstb_pkg::req_t dist_req(int a, int b, int v);
    lstb_pkg::req_t rq;
    rq = '0;
    rq.kind = lstb_pkg::KIND_DIST;
    rq.from_vertex = lstb_pkg::VERT_W'(a);
    rq.to_vertex = lstb_pkg::VERT_W'(b);
    rq.distance = 16'(v);
    rq.tour_vertex = lstb_pkg::VERT_W'($urandom);
    rq.restart = 1'($urandom_range(0, 1));
    return rq;
  endfunction

  function automatic lstb_pkg::req_t vert_req(int v, bit rs);
    lstb_pkg::req_t rq;
    rq = '0;
    rq.kind = lstb_pkg::KIND_APPEND;
    rq.tour_vertex = lstb_pkg::VERT_W'(v);
    rq.restart = rs;
    rq.from_vertex = lstb_pkg::VERT_W'($urandom);
    rq.to_vertex = lstb_pkg::VERT_W'($urandom);
    rq.distance = 16'($urandom);
    return rq;
  endfunction

  // writes a distance entry that an append will read, unless already written
  task automatic ensure_edge(input logic [lstb_pkg::VERT_W-1:0] a,
                             input logic [lstb_pkg::VERT_W-1:0] b);
    if (!dist_known[{a, b}])
      send_request(dist_req(int'(a), int'(b),
                            (edge_mode == 0) ? 65535 : int'($urandom_range(0, 65535))));
  endtask

  // appends a vertex, first writing both edges to the tour's last vertex when extending a non-empty, non-full tour
  task automatic send_append(input int v, input bit rs);
    logic [lstb_pkg::VERT_W-1:0] vv, pv;
    vv = lstb_pkg::VERT_W'(v);
    if (!rs && tour_len > 0 && tour_len < NV) begin
      pv = tour_mem[tour_len - 1];
      ensure_edge(pv, vv);
      ensure_edge(vv, pv);
    end
    send_request(vert_req(v, rs));
  endtask

  task automatic wait_drained();
    while (entry_q.size() != 0) @(negedge clk);
  endtask

  // directed: extremes, a full tour, overflow and restart on a full tour
  task automatic test_directed();
    edge_mode = 0;
    for (int p = 0; p < NV; p++) send_append(NV - 1 - p, p == 0);
    send_append(5, 1'b0);                      // full tour rejected
    send_append(31, 1'b1);                     // restart on a full tour
    send_append(0, 1'b0);
    send_request(dist_req(0, 31, 0));
    send_request(dist_req(31, 0, 0));
    send_append(31, 1'b0);
    wait_drained();
  endtask

  // receiver holds off long while the sender keeps offering appends
  task automatic test_backpressure();
    hold_cycles = 400;
    hold_out = 1'b1;
    for (int k = 0; k < 6; k++) send_append($urandom_range(0, RAND_V), k == 0);
    wait_drained();
  endtask

  task automatic test_random(input int count);
    int tour_goal;
    tour_goal = $urandom_range(1, 8);
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 19) == 0)
        send_request(dist_req($urandom_range(0, 31), $urandom_range(0, 31),
                              $urandom_range(0, 65535)));
      else if (tour_len >= tour_goal && $urandom_range(0, 4) != 0) begin
        // mostly short tours; now and then run one to full and beyond
        tour_goal = ($urandom_range(0, 9) == 0) ? NV + 2 : $urandom_range(1, 10);
        send_append($urandom_range(0, RAND_V), 1'b1);
      end else
        send_append($urandom_range(0, RAND_V), 1'b0);
      if (idle_on && k == count / 2) begin
        wait_drained();                        // sender pause until drained
        repeat ($urandom_range(1, 20)) @(negedge clk);
      end
    end
  endtask

  // result side stall generation: bursts, plus the long hold-off
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_out = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
        burst = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    lstb_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (entry_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
      end else begin
        want = entry_q.pop_front();
        if (out_data !== want) begin
          n_errors++;
          $display("%0t: mismatch, expected %p, actual %p", $time, want, out_data);
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    n_errors = 0;
    idle_on = 1'b1;
    hold_out = 1'b0;
    hold_cycles = 0;
    edge_mode = 0;
    tour_len = 0;
    for (int i = 0; i < NV; i++) begin
      tour_mem[i] = '0;
      col_dur[i] = '0;
      col_cost[i] = '0;
      col_wgt[i] = '0;
    end
    foreach (dist_mem[i]) dist_mem[i] = '0;
    foreach (dist_known[i]) dist_known[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    edge_mode = 1;
    test_backpressure();
    test_random(N_RANDOM * 3 / 4);
    idle_on = 1'b0;                            // closing part runs flat out
    test_random(N_RANDOM / 4);
    wait_drained();
    repeat (LAT_TAIL) @(negedge clk);
    if (n_errors == 0 && entry_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
